/* hdl/krbt_pkg.sv */
// Package for the key rank bucket table: sequencer states, status codes
// and default sizes. No dependencies.
`default_nettype none

package krbt_pkg;

  // Default number of key entries in the store
  localparam int unsigned StoreDepthDef = 256;

  // Reset value of the bucket count register
  localparam logic [4:0] BucketCountRst = 5'd6;

  // Result status codes
  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StEmpty    = 3'd4;

  // Command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIN
  } krbt_state_e;

endpackage

`default_nettype wire

/* hdl/key_rank_bucket_table_core.sv */
// Key rank bucket table: key store, scan sequencer and restoring
// divider. Depends on krbt_pkg.
`default_nettype none

// Usage:
// - Input channel: start/busy. A command (cmd_i, key_i) is taken at a rising
//   edge with start high and busy low. cmd_i 0 inserts key_i into the next
//   free entry, cmd_i 1 queries the rank and bucket of key_i.
// - Result channel: status_o, rank_o and bucket_o are valid for exactly one
//   cycle while result_valid_o is high. The receiver cannot stall it.
// - Config channel: cfg_data_i is written to the bucket count register when
//   cfg_valid_i and cfg_ready_o are both high; cfg_ready_o is always high.
// - An insert, or a query on an empty store, gives its result in the cycle
//   after the command; busy stays low, so one command per cycle.
// - A query scans the store one entry a cycle through the registered memory
//   read port and one 64-bit compare unit, multiplies once, then divides one
//   quotient bit a cycle.
//   A key that is not found skips the multiply and divide.
// - Reset clears the key count and sets the bucket count to 6. The key memory
//   is not cleared; only entries below the key count are ever read.
module key_rank_bucket_table_core
  import krbt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd_i,
  input  wire logic [63:0] key_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic [7:0]       rank_o,
  output logic [3:0]       bucket_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);

  localparam int unsigned IW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned PW  = CW + 5;
  localparam int unsigned BCW = $clog2(PW);

  // Control and status registers
  krbt_state_e      state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [4:0]       bcount_q, bcount_d;
  logic [CW-1:0]    issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             res_vld_q, res_vld_d;

  // Datapath registers
  logic [63:0]      key_q, key_d;
  logic [CW-1:0]    below_q, below_d;
  logic             hit_q, hit_d;
  logic [PW-1:0]    quo_q, quo_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [BCW-1:0]   bit_q, bit_d;
  logic [2:0]       status_q, status_d;
  logic [7:0]       rank_q, rank_d;
  logic [3:0]       bucket_q, bucket_d;

  // Key memory
  logic [63:0]      mem_q [STORE_DEPTH];
  logic [63:0]      rd_data_q;
  logic             we;
  logic [IW-1:0]    wr_addr;
  logic             re;
  logic [IW-1:0]    rd_addr;

  // Divider trial subtract
  logic [CW:0]      trial;
  logic [CW:0]      diff;
  logic             ge;

  logic             accept;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign rank_o         = rank_q;
  assign bucket_o       = bucket_q;

  assign trial = {rem_q, quo_q[PW-1]};
  assign diff  = trial - {1'b0, count_q};
  assign ge    = (trial >= {1'b0, count_q});

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= key_i;
    end
    if (re) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      bcount_q  <= BucketCountRst;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      bcount_q  <= bcount_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    below_q  <= below_d;
    hit_q    <= hit_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    bit_q    <= bit_d;
    status_q <= status_d;
    rank_q   <= rank_d;
    bucket_q <= bucket_d;
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    bcount_d  = bcount_q;
    issue_d   = issue_q;
    cmp_vld_d = 1'b0;
    res_vld_d = 1'b0;
    key_d     = key_q;
    below_d   = below_q;
    hit_d     = hit_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    status_d  = status_q;
    rank_d    = rank_q;
    bucket_d  = bucket_q;
    we        = 1'b0;
    wr_addr   = count_q[IW-1:0];
    re        = 1'b0;
    rd_addr   = issue_q[IW-1:0];

    if (cfg_valid_i && cfg_ready_o) begin
      bcount_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rank_d   = '0;
          bucket_d = '0;
          if (cmd_i == CmdInsert) begin
            res_vld_d = 1'b1;
            if (count_q != CW'(STORE_DEPTH)) begin
              we       = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = StInserted;
            end else begin
              status_d = StFull;
            end
          end else if (count_q == '0) begin
            res_vld_d = 1'b1;
            status_d  = StEmpty;
          end else begin
            key_d   = key_i;
            below_d = '0;
            hit_d   = 1'b0;
            issue_d = '0;
            state_d = S_SCAN;
          end
        end
      end

      // One read issued and one compare done per cycle
      S_SCAN: begin
        if (cmp_vld_q) begin
          if (rd_data_q < key_q) begin
            below_d = below_q + CW'(1);
          end else if (rd_data_q == key_q) begin
            hit_d = 1'b1;
          end
        end
        if (issue_q != count_q) begin
          re        = 1'b1;
          issue_d   = issue_q + CW'(1);
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          if (hit_q) begin
            state_d = S_MUL;
          end else begin
            res_vld_d = 1'b1;
            status_d  = StNotFound;
            state_d   = S_IDLE;
          end
        end
      end

      // Product rank * bucket count loads the dividend
      S_MUL: begin
        quo_d   = PW'(below_q) * PW'(bcount_q);
        rem_d   = '0;
        bit_d   = BCW'(PW - 1);
        state_d = S_DIV;
      end

      // Restoring divide by the key count, one quotient bit a cycle
      S_DIV: begin
        quo_d = {quo_q[PW-2:0], ge};
        rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];
        bit_d = bit_q - BCW'(1);
        if (bit_q == '0) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        res_vld_d = 1'b1;
        status_d  = StFound;
        rank_d    = 8'(below_q);
        bucket_d  = (quo_q > PW'(15)) ? 4'd15 : quo_q[3:0];
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
